### design/slcb_pkg.sv
// slcb_pkg: shared constants and types for the sign LSH code and bucket unit.
// No dependencies; used by sign_lsh_code_and_bucket_unit.
package slcb_pkg;

  localparam int unsigned MAX_CODE_BYTES  = 64;
  localparam int unsigned MAX_BUCKET_LOG2 = 16;

  localparam logic [2:0] BYTE_LANE_MASK = 3'h7;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // register reset values
  localparam logic [6:0] CODE_BYTES_RST   = 7'd1;
  localparam logic [4:0] BUCKET_LOG2_RST  = 5'd0;
  localparam logic [9:0] SEGMENT_LEN_RST  = 10'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_BYTES  = 2'd0,
    REG_BUCKET_LOG2 = 2'd1,
    REG_SEGMENT_LEN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] bucket_id;
    logic [5:0]  byte_index;
    logic [7:0]  code_byte;
  } out_beat_t;

endpackage

### design/sign_lsh_code_and_bucket_unit.sv
// sign_lsh_code_and_bucket_unit: builds sign-projection code bytes and a sampled bucket word.
// Depends on slcb_pkg.
//
// Usage:
//   in_*  : one projected value (signed Q16.16) per beat; only value > 0 matters.
//           8*code_bytes beats make one vector.
//   out_* : one beat per eight input beats carrying code_byte, byte_index and,
//           on the final byte of a vector (out_tlast high), the bucket id.
//   cfg_* : register writes (index, data); always ready. A write to a defined register restarts
//           the vector in progress. The user must write only while the unit is idle (not enforced).
// Result: a result beat is registered from the eighth value of a byte and appears in
//   the cycle after that value is taken. Throughput: one input beat per cycle while
//   no result beat is held and no cfg write is pending; the per-value update is a
//   single compare-and-count pass between the state registers and the output register.
// Reset: registers return to code_bytes=1, bucket_count_log2=0,
//   segment_length=8; the vector state restarts.
// Stall: a held result beat blocks new input only while out_tready is low.
module sign_lsh_code_and_bucket_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [slcb_pkg::IN_W-1:0]        in_tdata,   // [31:0] proj_value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [slcb_pkg::OUT_W-1:0]       out_tdata,  // [7:0] code_byte, [13:8] byte_index,
                                                       // [29:14] bucket_id, [31:30] zero
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slcb_pkg::CFG_W-1:0]       cfg_data
);

  // config registers
  logic [6:0]  code_bytes_r;
  logic [4:0]  bucket_log2_r;
  logic [9:0]  segment_len_r;

  // vector state
  logic [8:0]  bit_pos_r;
  logic [7:0]  partial_r;
  logic [9:0]  ones_r;
  logic [10:0] next_ckpt_r;
  logic [9:0]  watermark_r;
  logic [4:0]  sample_pos_r;
  logic [16:0] bucket_acc_r;

  // output register
  logic                  out_valid_r;
  slcb_pkg::out_beat_t   out_beat_r;
  logic                  out_last_r;

  // effective config
  logic [6:0]  bytes_eff;
  logic [4:0]  log2_eff;
  logic [9:0]  seg_eff;
  logic [9:0]  bit_max;
  logic [4:0]  bmax;

  // current-step state after restart
  logic        restart;
  logic [8:0]  bp_c;
  logic [7:0]  pb_c;
  logic [9:0]  oc_c;
  logic [10:0] ncp_c;
  logic [9:0]  wm_c;
  logic [4:0]  sbp_c;
  logic [16:0] acc_c;

  logic        bit_in;
  logic [2:0]  lane;
  logic        emit;
  logic        last;
  logic        hit;
  logic        sampled;
  logic [9:0]  remain;
  logic [16:0] bucket_mask;

  logic [7:0]  pb_nxt;
  logic [9:0]  oc_nxt;
  logic [10:0] ncp_nxt;
  logic [9:0]  wm_nxt;
  logic [4:0]  sbp_nxt;
  logic [16:0] acc_nxt;
  logic [8:0]  bp_nxt;
  logic [15:0] bucket_nxt;

  logic        in_acc;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign in_tready = (!out_valid_r || out_tready) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (code_bytes_r == 7'd0) begin
      bytes_eff = 7'd1;
    end else if (code_bytes_r > 7'(slcb_pkg::MAX_CODE_BYTES)) begin
      bytes_eff = 7'(slcb_pkg::MAX_CODE_BYTES);
    end else begin
      bytes_eff = code_bytes_r;
    end
    log2_eff = (bucket_log2_r > 5'(slcb_pkg::MAX_BUCKET_LOG2)) ?
               5'(slcb_pkg::MAX_BUCKET_LOG2) : bucket_log2_r;
    seg_eff  = (segment_len_r == 10'd0) ? 10'd1 : segment_len_r;
    bit_max  = {bytes_eff, 3'b000};
    bmax     = (log2_eff != 5'd0) ? log2_eff + 5'd1 : 5'd1;
  end

  always_comb begin
    restart = (bit_pos_r == 9'd0) || ({1'b0, bit_pos_r} >= bit_max);
    if (restart) begin
      bp_c  = 9'd0;
      pb_c  = 8'd0;
      oc_c  = 10'd0;
      ncp_c = {1'b0, seg_eff};
      wm_c  = {1'b0, seg_eff[9:1]};
      sbp_c = 5'd0;
      acc_c = 17'd0;
    end else begin
      bp_c  = bit_pos_r;
      pb_c  = partial_r;
      oc_c  = ones_r;
      ncp_c = next_ckpt_r;
      wm_c  = watermark_r;
      sbp_c = sample_pos_r;
      acc_c = bucket_acc_r;
    end

    bit_in = !in_tdata[slcb_pkg::IN_W-1] && (in_tdata != '0);
    lane   = bp_c[2:0];
    pb_nxt = pb_c | (8'(bit_in) << lane);
    oc_nxt = oc_c + 10'(bit_in);
    hit    = ({2'b00, bp_c} == ncp_c);

    sampled = (oc_nxt > wm_c);
    remain  = bit_max - ncp_c[9:0];
    ncp_nxt = ncp_c;
    wm_nxt  = wm_c;
    sbp_nxt = sbp_c;
    acc_nxt = acc_c;
    if (hit) begin
      oc_nxt = 10'd0;
      if (({1'b0, sbp_c} + 6'd2) == {1'b0, bmax}) begin
        wm_nxt  = {1'b0, remain[9:1]};
        ncp_nxt = {1'b0, bit_max - 10'd1};
      end else begin
        ncp_nxt = ncp_c + {1'b0, seg_eff};
      end
      if (sbp_c < bmax) begin
        acc_nxt = acc_c | (17'(sampled) << sbp_c);
        sbp_nxt = sbp_c + 5'd1;
      end
    end

    emit        = (lane == slcb_pkg::BYTE_LANE_MASK);
    last        = ({1'b0, bp_c} == (bit_max - 10'd1));
    bucket_mask = (17'd1 << log2_eff) - 17'd1;
    bucket_nxt  = (last && (log2_eff != 5'd0)) ? acc_nxt[15:0] & bucket_mask[15:0] : 16'd0;
    bp_nxt      = (emit && last) ? 9'd0 : bp_c + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bytes_r  <= slcb_pkg::CODE_BYTES_RST;
      bucket_log2_r <= slcb_pkg::BUCKET_LOG2_RST;
      segment_len_r <= slcb_pkg::SEGMENT_LEN_RST;
      bit_pos_r     <= 9'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (slcb_pkg::reg_idx_t'(cfg_index))
          slcb_pkg::REG_CODE_BYTES: begin
            code_bytes_r <= cfg_data[6:0];
            bit_pos_r    <= 9'd0;
          end
          slcb_pkg::REG_BUCKET_LOG2: begin
            bucket_log2_r <= cfg_data[4:0];
            bit_pos_r     <= 9'd0;
          end
          slcb_pkg::REG_SEGMENT_LEN: begin
            segment_len_r <= cfg_data;
            bit_pos_r     <= 9'd0;
          end
          default: begin
          end
        endcase
      end else if (in_acc) begin
        bit_pos_r <= bp_nxt;
      end
      if (in_acc) begin
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      partial_r    <= emit ? 8'd0 : pb_nxt;
      ones_r       <= oc_nxt;
      next_ckpt_r  <= ncp_nxt;
      watermark_r  <= wm_nxt;
      sample_pos_r <= sbp_nxt;
      bucket_acc_r <= acc_nxt;
      if (emit) begin
        out_beat_r.code_byte  <= pb_nxt;
        out_beat_r.byte_index <= bp_c[8:3];
        out_beat_r.bucket_id  <= bucket_nxt;
        out_last_r            <= last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_beat_r};
  assign out_tlast  = out_last_r;

  a_bucket_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_beat_r.bucket_id == 16'd0)
    else $error("bucket id on non-final byte");

  a_sample_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> sbp_nxt <= 5'(slcb_pkg::MAX_BUCKET_LOG2 + 1))
    else $error("sampled bit position overflow");

  a_emit_on_lane7: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit |=> out_valid_r)
    else $error("completed byte not presented");

  a_no_emit_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !emit |=> !out_valid_r)
    else $error("result beat from partial byte");

endmodule

### tb/sv/sign_lsh_code_and_bucket_unit_test.sv
// Self-checking testbench for sign_lsh_code_and_bucket_unit: streams projected values, predicts
// each code byte and bucket id, and checks every result beat in order.
// Depends on slcb_pkg and the unit's RTL.
`timescale 1ns / 100ps

module sign_lsh_code_and_bucket_unit_test;

  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [5:0]  byte_index;
    logic [15:0] bucket_id;
    logic        last;
  } code_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  logic [31:0] pending_values[$];
  code_beat_t  expected_codes[$];
  int unsigned failures = 0;
  logic        no_gaps = 1'b0;

  // predictor copy of the registers and the per-vector state
  logic [6:0]  code_bytes_r;
  logic [4:0]  bucket_log2_r;
  logic [9:0]  segment_len_r;
  logic [8:0]  bit_pos;
  logic [7:0]  byte_acc;
  logic [9:0]  ones_cnt;
  logic [10:0] next_cp;
  logic [9:0]  watermark;
  logic [4:0]  sample_pos;
  logic [16:0] bucket_acc;

  sign_lsh_code_and_bucket_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [31:0] proj_value
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [7:0] code_byte, [13:8] byte_index, [29:14] bucket_id
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned code_bits();
    if (code_bytes_r == 0) return 8;
    if (code_bytes_r > slcb_pkg::MAX_CODE_BYTES) return slcb_pkg::MAX_CODE_BYTES * 8;
    return code_bytes_r * 8;
  endfunction

  function automatic int unsigned bucket_log2();
    return (bucket_log2_r > slcb_pkg::MAX_BUCKET_LOG2) ? slcb_pkg::MAX_BUCKET_LOG2
                                                       : bucket_log2_r;
  endfunction

  function automatic int unsigned seg_len();
    return (segment_len_r == 0) ? 1 : segment_len_r;
  endfunction

  task automatic restart_vector();
    bit_pos    = '0;
    byte_acc   = '0;
    ones_cnt   = '0;
    next_cp    = 11'(seg_len());
    watermark  = 10'(seg_len() >> 1);
    sample_pos = '0;
    bucket_acc = '0;
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [9:0] data);
    case (idx)
      slcb_pkg::REG_CODE_BYTES:  code_bytes_r  = data[6:0];
      slcb_pkg::REG_BUCKET_LOG2: bucket_log2_r = data[4:0];
      slcb_pkg::REG_SEGMENT_LEN: segment_len_r = data;
      default: return;
    endcase
    restart_vector();
  endtask

  // one accepted value: update the sign code and the sampled bucket word
  task automatic take_value(input logic [31:0] value);
    int unsigned bits, lg, bmax;
    logic        sign_bit, sampled, is_last;
    code_beat_t  beat;
    bits = code_bits();
    lg   = bucket_log2();
    bmax = (lg > 0) ? lg + 1 : 1;
    if (bit_pos == 0 || bit_pos >= bits) restart_vector();
    sign_bit = (value != 0) && !value[31];
    byte_acc = byte_acc | (8'(sign_bit) << bit_pos[2:0]);
    ones_cnt = ones_cnt + 10'(sign_bit);
    if ({2'b00, bit_pos} == next_cp) begin
      sampled  = ones_cnt > watermark;
      ones_cnt = '0;
      if (sample_pos + 2 == bmax) begin
        watermark = 10'((bits - next_cp) >> 1);
        next_cp   = 11'(bits - 1);
      end else begin
        next_cp = next_cp + 11'(seg_len());
      end
      if (sample_pos < bmax) begin
        bucket_acc[sample_pos] = bucket_acc[sample_pos] | sampled;
        sample_pos++;
      end
    end
    if (bit_pos[2:0] != slcb_pkg::BYTE_LANE_MASK) begin
      bit_pos++;
      return;
    end
    is_last = (bit_pos == bits - 1);
    beat.code_byte  = byte_acc;
    beat.byte_index = 6'(bit_pos >> 3);
    beat.bucket_id  = (is_last && lg > 0) ? 16'(bucket_acc & ((1 << lg) - 1)) : 16'd0;
    beat.last       = is_last;
    expected_codes.push_back(beat);
    byte_acc = '0;
    bit_pos  = is_last ? 9'd0 : bit_pos + 9'd1;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_tvalid || expected_codes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value(input int unsigned pct_pos);
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if ($urandom_range(99) < pct_pos) return {1'b0, 31'($urandom)};
    return {1'b1, 31'($urandom)};
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_values.size() != 0 && (no_gaps || $urandom_range(99) >= 24)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_values.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(99) >= 24);
    end
  end

  // monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin : monitor_blk
    code_beat_t          want;
    slcb_pkg::out_beat_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) take_value(in_tdata);
      if (out_tvalid && out_tready) begin
        got = slcb_pkg::out_beat_t'(out_tdata[29:0]);
        if (expected_codes.size() == 0) begin
          $error("unexpected result beat: tdata %h last %b", out_tdata, out_tlast);
          failures++;
        end else begin
          want = expected_codes.pop_front();
          if (got.code_byte !== want.code_byte) begin
            $error("code_byte: expected %h, got %h", want.code_byte, got.code_byte);
            failures++;
          end
          if (got.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
            failures++;
          end
          if (got.bucket_id !== want.bucket_id) begin
            $error("bucket_id: expected %h, got %h", want.bucket_id, got.bucket_id);
            failures++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            failures++;
          end
          if (out_tdata[31:30] !== 2'b00) begin
            $error("pad: expected 0, got %b", out_tdata[31:30]);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned sent, phase, bits, lg, bmax, nvec, pct, cut, seg;
    logic [6:0]  cb;
    logic [4:0]  lgr;
    code_bytes_r  = slcb_pkg::CODE_BYTES_RST;
    bucket_log2_r = slcb_pkg::BUCKET_LOG2_RST;
    segment_len_r = slcb_pkg::SEGMENT_LEN_RST;
    restart_vector();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes on the reset settings
    pending_values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h4000_0000};
    wait_idle();
    // partial vector, unused index ignored, then a real write abandons it
    pending_values.push_back(32'h0000_0005);
    pending_values.push_back(32'h8000_0001);
    wait_idle();
    write_reg(REG_NONE, 10'h3FF);
    write_reg(slcb_pkg::REG_CODE_BYTES, 10'd2);
    write_reg(slcb_pkg::REG_BUCKET_LOG2, 10'd1);
    write_reg(slcb_pkg::REG_SEGMENT_LEN, 10'd3);
    for (int i = 0; i < 16; i++) pending_values.push_back(i < 5 ? 32'h0000_0100 : rand_value(50));
    wait_idle();

    sent  = 0;
    phase = 0;
    while (sent < 1800) begin
      phase++;
      no_gaps = (phase >= 6 && phase < 9);
      case ($urandom_range(99)) inside
        [0:7]:   cb = 7'd64;
        [8:11]:  cb = 7'h7F;
        [12:16]: cb = 7'd0;
        [17:21]: cb = 7'd1;
        default: cb = 7'($urandom_range(2, 24));
      endcase
      case ($urandom_range(99)) inside
        [0:14]:  lgr = 5'd0;
        [15:24]: lgr = 5'd16;
        [25:29]: lgr = 5'($urandom_range(17, 31));
        default: lgr = 5'($urandom_range(1, 15));
      endcase
      bits = (cb == 0) ? 8 : (cb > slcb_pkg::MAX_CODE_BYTES ? slcb_pkg::MAX_CODE_BYTES * 8
                                                            : cb * 8);
      lg   = (lgr > slcb_pkg::MAX_BUCKET_LOG2) ? slcb_pkg::MAX_BUCKET_LOG2 : lgr;
      bmax = (lg > 0) ? lg + 1 : 1;
      case ($urandom_range(99)) inside
        [0:49]:  seg = (bits / bmax == 0) ? 1 : bits / bmax;
        [50:57]: seg = 0;
        [58:63]: seg = 1;
        [64:69]: seg = 512;
        [70:74]: seg = 1023;
        default: seg = $urandom_range(1, 64);
      endcase
      write_reg(slcb_pkg::REG_CODE_BYTES, {3'($urandom), cb});
      write_reg(slcb_pkg::REG_BUCKET_LOG2, {5'($urandom), lgr});
      write_reg(slcb_pkg::REG_SEGMENT_LEN, 10'(seg));
      nvec = $urandom_range(1, (160 / bits > 1) ? 160 / bits : 1);
      for (int v = 0; v < nvec; v++) begin
        pct = $urandom_range(0, 100);
        cut = (v == nvec - 1 && $urandom_range(99) < 20) ? $urandom_range(1, bits - 1) : bits;
        for (int i = 0; i < cut; i++) pending_values.push_back(rand_value(pct));
        sent += cut;
      end
      wait_idle();
    end
    no_gaps = 1'b0;
    wait_idle();

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
